// ===== rtl/rbrc_pkg.sv =====
// Shared types and constants for the ring buffer refill controller.
// Used by rbrc_core and ring_buffer_refill_controller; depends on nothing.
package rbrc_pkg;

  localparam int unsigned RING_BYTES  = 16384;
  localparam int unsigned CHUNK_BYTES = 4096;
  localparam int unsigned OffsW       = $clog2(RING_BYTES);
  localparam int unsigned ChunkW      = $clog2(CHUNK_BYTES);
  localparam int unsigned BytesW      = 15;

  localparam logic [OffsW-1:0]  ChunkStep   = OffsW'(CHUNK_BYTES);
  localparam logic [BytesW-1:0] ChunkLen    = BytesW'(CHUNK_BYTES);
  localparam logic [BytesW-1:0] TwoChunkLen = BytesW'(2 * CHUNK_BYTES);
  localparam logic [BytesW-1:0] RingLen     = BytesW'(RING_BYTES);

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_ATTACH = 2'd1,
    FUNC_CLEAR  = 2'd2
  } rbrc_func_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_CHUNK   = 3'd1,
    ACT_RESYNC  = 3'd2,
    ACT_ATTACH  = 3'd3,
    ACT_SILENCE = 3'd4
  } rbrc_action_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] cursor;
  } rbrc_in_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [13:0]       fill_offset;
    logic [BytesW-1:0] fill_bytes;
  } rbrc_out_t;

  typedef struct packed {
    logic [OffsW-1:0] valid_start;
    logic [OffsW-1:0] trigger_point;
    logic [OffsW-1:0] next_fill;
    logic             channel_active;
  } rbrc_state_t;

  // True when p lies in the window [s, e); a window with s >= e wraps.
  function automatic logic in_window(logic [OffsW-1:0] p, logic [OffsW-1:0] s,
                                     logic [OffsW-1:0] e);
    if (s < e) begin
      return (p >= s) && (p < e);
    end
    return (p >= s) || (p < e);
  endfunction

endpackage

// ===== rtl/rbrc_core.sv =====
// Decision logic: from the held item and the current offsets, forms the
// result and the next offsets. Depends on rbrc_pkg.
module rbrc_core import rbrc_pkg::*; (
  input  rbrc_in_t    item_i,
  input  rbrc_state_t state_i,
  output rbrc_out_t   result_o,
  output rbrc_state_t state_o
);

  logic [OffsW-1:0]  cur;
  logic [ChunkW-1:0] rem;
  logic [OffsW-1:0]  rs_start;
  logic [OffsW-1:0]  rs_trig;
  logic [BytesW-1:0] rs_bytes;
  rbrc_state_t       rs_state;

  // The cursor is taken modulo the ring size.
  assign cur      = item_i.cursor[OffsW-1:0];
  assign rem      = cur[ChunkW-1:0];
  assign rs_start = {cur[OffsW-1:ChunkW], {ChunkW{1'b0}}};
  assign rs_trig  = rs_start + ChunkStep;
  assign rs_bytes = TwoChunkLen - BytesW'(rem);

  always_comb begin
    rs_state                = state_i;
    rs_state.valid_start    = rs_start;
    rs_state.trigger_point  = rs_trig;
    rs_state.next_fill      = rs_trig + ChunkStep;
  end

  always_comb begin
    result_o = '{action: ACT_NONE, fill_offset: '0, fill_bytes: '0};
    state_o  = state_i;
    unique case (item_i.func)
      FUNC_UPDATE: begin
        if (state_i.channel_active) begin
          if (!in_window(cur, state_i.valid_start, state_i.next_fill)) begin
            result_o = '{action: ACT_RESYNC, fill_offset: 14'(cur), fill_bytes: rs_bytes};
            state_o  = rs_state;
          end else if (in_window(cur, state_i.trigger_point, state_i.next_fill)) begin
            result_o = '{action: ACT_CHUNK, fill_offset: 14'(state_i.next_fill),
                         fill_bytes: ChunkLen};
            state_o.valid_start   = state_i.trigger_point;
            state_o.trigger_point = state_i.next_fill;
            state_o.next_fill     = state_i.next_fill + ChunkStep;
          end
        end
      end
      FUNC_ATTACH: begin
        result_o = '{action: ACT_ATTACH, fill_offset: 14'(cur), fill_bytes: rs_bytes};
        state_o  = rs_state;
        state_o.channel_active = 1'b1;
      end
      FUNC_CLEAR: begin
        result_o = '{action: ACT_SILENCE, fill_offset: '0, fill_bytes: RingLen};
        state_o.channel_active = 1'b0;
      end
      default: begin
        // The unused function code leaves everything as it is.
      end
    endcase
  end

endmodule

// ===== rtl/ring_buffer_refill_controller.sv =====
// An item is held in the input register, its result in the result register until taken.
// Throughput: one item per cycle unless stalled; the offsets update with the result register.
// While a result waits to be taken, the input register can still take an item if it is empty.
// Reset (asynchronous, active low) clears the offsets, the active flag and both valid bits.
// Top level of the ring buffer refill controller; depends on rbrc_pkg and rbrc_core.
module ring_buffer_refill_controller import rbrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rbrc_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rbrc_out_t out_item_o
);

  logic        in_valid_q, in_valid_d;
  rbrc_in_t    in_item_q;
  logic        out_valid_q, out_valid_d;
  rbrc_out_t   out_item_q;
  rbrc_state_t state_q, state_d;
  rbrc_out_t   core_result;
  logic        advance;
  logic        load;

  rbrc_core u_core (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .result_o (core_result),
    .state_o  (state_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  assign in_valid_d  = load | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= core_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // While active, the offsets stay one chunk apart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.channel_active |->
      (state_q.trigger_point == state_q.valid_start + ChunkStep) &&
      (state_q.next_fill == state_q.trigger_point + ChunkStep))
    else $error("active channel offsets are not one chunk apart");

  // The state seen with a held result is the one that result produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_item_q.action == ACT_ATTACH) |-> state_q.channel_active)
    else $error("attach result without an active channel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_item_q.action == ACT_SILENCE) |-> !state_q.channel_active)
    else $error("silence result with the channel still active");

  // A chunk refill always starts one chunk behind the new fill point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_item_q.action == ACT_CHUNK) |->
      (state_q.next_fill == out_item_q.fill_offset[OffsW-1:0] + ChunkStep))
    else $error("chunk refill offset does not match the fill point");

endmodule
